@@ design/assert_macros.svh @@
// assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SLMP_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define SLMP_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ design/slmp_pkg.sv @@
// types, constants and helpers of the linear move planner
`default_nettype none
package slmp_pkg;

   localparam logic [31:0] SCALE_RESET = 32'd16777216;
   localparam logic        REG_SCALE   = 1'b0;

   localparam logic [15:0] SPD_QUIET_LIMIT  = 16'd350;
   localparam logic [15:0] SPD_SPREAD_LIMIT = 16'd550;
   localparam logic [15:0] SPD_MID_LIMIT    = 16'd800;

   localparam logic [4:0] DIV_FINE   = 5'd16;
   localparam logic [4:0] DIV_MEDIUM = 5'd8;
   localparam logic [4:0] DIV_COARSE = 5'd2;

   localparam logic [4:0] CUR_LOW  = 5'd8;
   localparam logic [4:0] CUR_MID  = 5'd17;
   localparam logic [4:0] CUR_HIGH = 5'd26;

   localparam logic [31:0] RECIP_FIVE = 32'hCCCCCCCD;

   localparam logic [24:0] START_MIN   = 25'd50;
   localparam logic [25:0] RAMP_MIN    = 26'd20;
   localparam logic [29:0] SHORT_LIMIT = 30'd100;
   localparam logic [23:0] FREQ_MAX    = 24'hFFFFFF;

   localparam logic [2:0] SEG_ACC1   = 3'd0;
   localparam logic [2:0] SEG_ACC2   = 3'd1;
   localparam logic [2:0] SEG_CRUISE = 3'd2;
   localparam logic [2:0] SEG_DEC1   = 3'd3;
   localparam logic [2:0] SEG_DEC2   = 3'd4;

   typedef struct packed {
      logic       err;
      logic       fwd;
      logic [4:0] div;
      logic       mode;
      logic [4:0] cur;
   } tag_type;

   typedef struct packed {
      logic               vld;
      tag_type            tag;
      logic               short_move;
      logic [29:0]        total;
      logic [27:0]        target;
      logic [24:0]        start;
      logic [25:0]        ramp;
      logic signed [29:0] diff;
   } kin_type;

   typedef struct packed {
      logic        status;
      logic        forward;
      logic [4:0]  microstep_div;
      logic        spread_mode;
      logic [4:0]  run_current_code;
      logic [2:0]  segment_index;
      logic [31:0] segment_steps;
      logic [23:0] begin_freq_hz;
      logic [23:0] finish_freq_hz;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic adv;
      logic busy;
   } seq_stat_type;

   function automatic logic [23:0] sat_freq(input logic [29:0] v);
      logic [23:0] r;
      r = (v > {6'b0, FREQ_MAX}) ? FREQ_MAX : v[23:0];
      return r;
   endfunction

endpackage
`default_nettype wire

@@ design/slmp_csr.sv @@
// configuration register file with apb-style access
`default_nettype none
module slmp_csr (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output logic [31:0] scale
);
   import slmp_pkg::*;

   logic [31:0] scale_ff;
   logic [31:0] scale_in;
   logic        hit;

   assign hit        = (csr_paddr[2] == REG_SCALE);
   assign csr_pready = 1'b1;
   assign csr_prdata = hit ? scale_ff : 32'd0;
   assign scale      = scale_ff;

   always_comb begin
      scale_in = scale_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && hit) begin
         scale_in = csr_pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RESET;
      end else begin
         scale_ff <= scale_in;
      end
   end

endmodule
`default_nettype wire

@@ design/slmp_kin.sv @@
// four-stage kinematics pipeline: band decode, scaling, reciprocal divides, clamps
`default_nettype none
module slmp_kin (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 req_valid,
   input  logic signed [18:0]   distance_um,
   input  logic [15:0]          speed_ums,
   input  logic [31:0]          scale,
   output slmp_pkg::kin_type    kin
);
   import slmp_pkg::*;

   // stage 1
   logic        s1_vld_ff, s1_vld_in;
   tag_type     s1_tag_ff, s1_tag_in;
   logic [22:0] s1_md_ff, s1_md_in;
   logic [19:0] s1_sd_ff, s1_sd_in;
   logic [18:0] mag;

   // stage 2
   logic        s2_vld_ff;
   tag_type     s2_tag_ff;
   logic [29:0] s2_total_ff, s2_total_in;
   logic [27:0] s2_target_ff, s2_target_in;
   logic [54:0] prod_total;
   logic [51:0] prod_target;

   // stage 3
   logic        s3_vld_ff;
   tag_type     s3_tag_ff;
   logic [29:0] s3_total_ff;
   logic [27:0] s3_target_ff;
   logic [24:0] s3_q10_ff, s3_q10_in;
   logic [25:0] s3_q20_ff, s3_q20_in;
   logic [59:0] prod_q10;
   logic [59:0] prod_q20;

   // stage 4
   kin_type     s4_ff, s4_in;

   always_comb begin
      mag = distance_um[18] ? (~distance_um + 19'd1) : distance_um;
      s1_vld_in = req_valid;
      s1_tag_in.err = (mag == 19'd0) || (speed_ums == 16'd0);
      s1_tag_in.fwd = ~distance_um[18];
      if (speed_ums < SPD_QUIET_LIMIT) begin
         s1_tag_in.div  = DIV_FINE;
         s1_tag_in.mode = 1'b0;
         s1_tag_in.cur  = CUR_LOW;
         s1_md_in       = {mag, 4'b0};
         s1_sd_in       = {speed_ums, 4'b0};
      end else if (speed_ums <= SPD_SPREAD_LIMIT) begin
         s1_tag_in.div  = DIV_FINE;
         s1_tag_in.mode = 1'b1;
         s1_tag_in.cur  = CUR_MID;
         s1_md_in       = {mag, 4'b0};
         s1_sd_in       = {speed_ums, 4'b0};
      end else if (speed_ums <= SPD_MID_LIMIT) begin
         s1_tag_in.div  = DIV_MEDIUM;
         s1_tag_in.mode = 1'b1;
         s1_tag_in.cur  = CUR_HIGH;
         s1_md_in       = {1'b0, mag, 3'b0};
         s1_sd_in       = {1'b0, speed_ums, 3'b0};
      end else begin
         s1_tag_in.div  = DIV_COARSE;
         s1_tag_in.mode = 1'b1;
         s1_tag_in.cur  = CUR_HIGH;
         s1_md_in       = {3'b0, mag, 1'b0};
         s1_sd_in       = {3'b0, speed_ums, 1'b0};
      end
   end

   assign prod_total   = {32'b0, s1_md_ff} * {23'b0, scale};
   assign prod_target  = {32'b0, s1_sd_ff} * {20'b0, scale};
   assign s2_total_in  = prod_total[53:24];
   assign s2_target_in = prod_target[51:24];

   // divide by ten and by twenty through the reciprocal of five
   assign prod_q10  = {32'b0, s2_target_ff} * {28'b0, RECIP_FIVE};
   assign prod_q20  = {32'b0, s2_total_ff[29:2]} * {28'b0, RECIP_FIVE};
   assign s3_q10_in = prod_q10[59:35];
   assign s3_q20_in = prod_q20[59:34];

   always_comb begin
      s4_in.vld        = s3_vld_ff;
      s4_in.tag        = s3_tag_ff;
      s4_in.total      = s3_total_ff;
      s4_in.target     = s3_target_ff;
      s4_in.short_move = (s3_total_ff < SHORT_LIMIT);
      s4_in.start      = (s3_q10_ff < START_MIN) ? START_MIN : s3_q10_ff;
      s4_in.ramp       = (s3_q20_ff < RAMP_MIN) ? RAMP_MIN : s3_q20_ff;
      s4_in.diff       = $signed({2'b0, s3_target_ff}) - $signed({5'b0, s4_in.start});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_ff.vld <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= s1_vld_in;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_ff.vld <= s4_in.vld;
      end
      if (adv) begin
         s1_tag_ff    <= s1_tag_in;
         s1_md_ff     <= s1_md_in;
         s1_sd_ff     <= s1_sd_in;
         s2_tag_ff    <= s1_tag_ff;
         s2_total_ff  <= s2_total_in;
         s2_target_ff <= s2_target_in;
         s3_tag_ff    <= s2_tag_ff;
         s3_total_ff  <= s2_total_ff;
         s3_target_ff <= s2_target_ff;
         s3_q10_ff    <= s3_q10_in;
         s3_q20_ff    <= s3_q20_in;
         s4_ff.tag        <= s4_in.tag;
         s4_ff.short_move <= s4_in.short_move;
         s4_ff.total      <= s4_in.total;
         s4_ff.target     <= s4_in.target;
         s4_ff.start      <= s4_in.start;
         s4_ff.ramp       <= s4_in.ramp;
         s4_ff.diff       <= s4_in.diff;
      end
   end

   assign kin = s4_ff;

endmodule
`default_nettype wire

@@ design/slmp_seq.sv @@
// plan register and segment sequencer with output register
`default_nettype none
module slmp_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  slmp_pkg::kin_type      kin,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output slmp_pkg::rsp_type      rsp,
   output slmp_pkg::seq_stat_type stat
);
   import slmp_pkg::*;

   logic signed [29:0] half;
   logic signed [29:0] mid_a;
   logic signed [29:0] mid_d;

   logic        p_vld_ff;
   logic [2:0]  p_seg_ff, p_seg_in;
   tag_type     p_tag_ff;
   logic        p_short_ff;
   logic [29:0] p_total_ff;
   logic [31:0] p_a1_ff, p_a1_in;
   logic [31:0] p_a2_ff, p_a2_in;
   logic [31:0] p_cruise_ff, p_cruise_in;
   logic [23:0] p_start_ff, p_mida_ff, p_target_ff, p_midd_ff;

   logic        o_vld_ff, o_vld_in;
   rsp_type     o_ff, o_in;

   logic        out_load;
   logic        seg_last;
   logic        p_done;
   logic        adv;

   always_comb begin
      // halve toward zero
      half  = (kin.diff + $signed({29'b0, kin.diff[29]})) >>> 1;
      mid_a = $signed({5'b0, kin.start}) + half;
      mid_d = $signed({2'b0, kin.target}) - half;
      p_cruise_in = {2'b0, kin.total} - {5'b0, kin.ramp, 1'b0};
      p_a1_in     = {7'b0, kin.ramp[25:1]};
      p_a2_in     = {6'b0, kin.ramp} - p_a1_in;
   end

   assign seg_last = p_tag_ff.err || p_short_ff || (p_seg_ff == SEG_DEC2);
   assign out_load = p_vld_ff && (!o_vld_ff || rsp_ready);
   assign p_done   = out_load && seg_last;
   assign adv      = !p_vld_ff || p_done;

   always_comb begin
      p_seg_in = p_seg_ff;
      if (adv) begin
         p_seg_in = SEG_ACC1;
      end else if (out_load) begin
         p_seg_in = p_seg_ff + 3'd1;
      end
   end

   always_comb begin
      o_in                  = '0;
      o_in.forward          = p_tag_ff.fwd;
      o_in.microstep_div    = p_tag_ff.div;
      o_in.spread_mode      = p_tag_ff.mode;
      o_in.run_current_code = p_tag_ff.cur;
      o_in.segment_index    = p_seg_ff;
      o_in.last             = seg_last;
      case (p_seg_ff)
         SEG_ACC1: begin
            o_in.segment_steps  = p_a1_ff;
            o_in.begin_freq_hz  = p_start_ff;
            o_in.finish_freq_hz = p_mida_ff;
         end
         SEG_ACC2: begin
            o_in.segment_steps  = p_a2_ff;
            o_in.begin_freq_hz  = p_mida_ff;
            o_in.finish_freq_hz = p_target_ff;
         end
         SEG_CRUISE: begin
            o_in.segment_steps  = p_cruise_ff;
            o_in.begin_freq_hz  = p_target_ff;
            o_in.finish_freq_hz = p_target_ff;
         end
         SEG_DEC1: begin
            o_in.segment_steps  = p_a1_ff;
            o_in.begin_freq_hz  = p_target_ff;
            o_in.finish_freq_hz = p_midd_ff;
         end
         SEG_DEC2: begin
            o_in.segment_steps  = p_a2_ff;
            o_in.begin_freq_hz  = p_midd_ff;
            o_in.finish_freq_hz = p_start_ff;
         end
         default: begin
            o_in.segment_steps  = 32'd0;
            o_in.begin_freq_hz  = 24'd0;
            o_in.finish_freq_hz = 24'd0;
         end
      endcase
      if (p_short_ff) begin
         o_in.segment_steps  = {2'b0, p_total_ff};
         o_in.begin_freq_hz  = p_target_ff;
         o_in.finish_freq_hz = p_target_ff;
      end
      if (p_tag_ff.err) begin
         o_in        = '0;
         o_in.status = 1'b1;
         o_in.last   = 1'b1;
      end
   end

   always_comb begin
      o_vld_in = o_vld_ff;
      if (out_load) begin
         o_vld_in = 1'b1;
      end else if (rsp_ready) begin
         o_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_vld_ff <= 1'b0;
         p_seg_ff <= SEG_ACC1;
         o_vld_ff <= 1'b0;
      end else begin
         p_seg_ff <= p_seg_in;
         o_vld_ff <= o_vld_in;
         if (adv) begin
            p_vld_ff <= kin.vld;
         end
      end
      if (adv) begin
         p_tag_ff    <= kin.tag;
         p_short_ff  <= kin.short_move;
         p_total_ff  <= kin.total;
         p_a1_ff     <= p_a1_in;
         p_a2_ff     <= p_a2_in;
         p_cruise_ff <= p_cruise_in;
         p_start_ff  <= sat_freq({5'b0, kin.start});
         p_target_ff <= sat_freq({2'b0, kin.target});
         p_mida_ff   <= sat_freq(mid_a);
         p_midd_ff   <= sat_freq(mid_d);
      end
      if (out_load) begin
         o_ff <= o_in;
      end
   end

   assign rsp_valid = o_vld_ff;
   assign rsp       = o_ff;
   assign stat.adv  = adv;
   assign stat.busy = p_vld_ff;

endmodule
`default_nettype wire

@@ design/stepper_linear_move_planner_unit.sv @@
// top level of the linear move planner
//
// A move request enters a four-stage kinematics pipeline (speed band decode,
// distance and speed scaling, reciprocal divides, clamps) and then a plan
// register that a segment sequencer drains into the output register, one
// segment per cycle while rsp_tready does not stall the output. A rejected or
// short move gives one result and the unit then takes a request every cycle
// while the output is not stalled; a long move gives five results and holds
// the plan register, stalling the pipeline, until its last segment is loaded
// into the output register.
`default_nettype none
`include "assert_macros.svh"
module stepper_linear_move_planner_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // distance_um[18:0], speed_ums[34:19], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // forward, microstep_div, spread_mode,
                                    // run_current_code, segment_index,
                                    // segment_steps, begin_freq_hz,
                                    // finish_freq_hz, zero pad
   output logic        rsp_tuser,   // status
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import slmp_pkg::*;

   logic [31:0]  scale;
   kin_type      kin;
   rsp_type      rsp;
   seq_stat_type stat;

   slmp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .scale       (scale)
   );

   slmp_kin u_kin (
      .clock       (clock),
      .reset       (reset),
      .adv         (stat.adv),
      .req_valid   (req_tvalid),
      .distance_um ($signed(req_tdata[18:0])),
      .speed_ums   (req_tdata[34:19]),
      .scale       (scale),
      .kin         (kin)
   );

   slmp_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .kin       (kin),
      .rsp_ready (rsp_tready),
      .rsp_valid (rsp_tvalid),
      .rsp       (rsp),
      .stat      (stat)
   );

   assign req_tready = stat.adv && !reset;
   assign rsp_tuser  = rsp.status;
   assign rsp_tlast  = rsp.last;
   assign rsp_tdata  = {1'b0, rsp.finish_freq_hz, rsp.begin_freq_hz, rsp.segment_steps,
                        rsp.segment_index, rsp.run_current_code, rsp.spread_mode,
                        rsp.microstep_div, rsp.forward};

   // a rejected request is always a single result
   `SLMP_ASSERT_NOW(a_reject_single, clock, reset, rsp_tvalid && rsp_tuser, rsp_tlast)
   // segment numbers stay in range
   `SLMP_ASSERT_NOW(a_seg_range, clock, reset, rsp_tvalid, rsp_tdata[14:12] <= SEG_DEC2)
   // an empty plan register never blocks the pipeline
   `SLMP_ASSERT_NOW(a_idle_ready, clock, reset, !stat.busy, req_tready)
   // a non-final result is followed by another from the same plan
   `SLMP_ASSERT_NEXT(a_plan_held, clock, reset,
      rsp_tvalid && rsp_tready && !rsp_tlast, rsp_tvalid)

endmodule
`default_nettype wire
